// ----- sv/wbs_pkg.sv -----
// ----------------------------------------------------------------------------
// wbs_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbs_pkg;

  localparam int PAT_BYTES = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int DISP_W    = 32;
  localparam int LEN_REG_W = 5;
  localparam int ROFF_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW     = 3'd0,
    CFG_PATTERN_HIGH    = 3'd1,
    CFG_CARE_MASK       = 3'd2,
    CFG_PATTERN_LENGTH  = 3'd3,
    CFG_RELATIVE_OFFSET = 3'd4,
    CFG_KEEP_LAST       = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [2*CFG_W-1:0]     pattern;
    logic [PAT_BYTES-1:0]   care_mask;
    logic [LEN_REG_W-1:0]   pattern_length;
    logic [ROFF_W-1:0]      relative_offset;
    logic                   keep_last;
  } cfg_regs_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic keep_last;
    logic off_err;
  } scan_flags_t;

  localparam int FLAGS_W = $bits(scan_flags_t);

endpackage

// ----- sv/wbs_in_if.sv -----
// ----------------------------------------------------------------------------
// wbs_in_if
// Byte request channel: one addressed byte per request.
// ----------------------------------------------------------------------------
interface wbs_in_if #(
  parameter int ADDRESS_BITS = 48
);
  logic                    valid;
  logic                    ready;
  logic [7:0]              data_byte;
  logic [ADDRESS_BITS-1:0] byte_address;
  logic                    last_in_range;

  modport source (output valid, data_byte, byte_address, last_in_range, input ready);
  modport sink   (input valid, data_byte, byte_address, last_in_range, output ready);
endinterface

// ----- sv/wbs_out_if.sv -----
// ----------------------------------------------------------------------------
// wbs_out_if
// Result request channel: one scan result per range.
// ----------------------------------------------------------------------------
interface wbs_out_if #(
  parameter int ADDRESS_BITS = 48
);
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [ADDRESS_BITS-1:0] result_address;
  logic                    multiple_matches;
  logic                    offset_error;

  modport source (output valid, found, result_address, multiple_matches, offset_error,
                  input ready);
  modport sink   (input valid, found, result_address, multiple_matches, offset_error,
                  output ready);
endinterface

// ----- sv/wbs_fifo.sv -----
// ----------------------------------------------------------------------------
// wbs_fifo
// Two-entry queue between the classify front and the result back.
// ----------------------------------------------------------------------------
module wbs_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              not_empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue underflow");

endmodule

// ----- sv/wbs_front.sv -----
// ----------------------------------------------------------------------------
// wbs_front
// Byte window, wildcard compare and match classification per request.
// ----------------------------------------------------------------------------
module wbs_front
  import wbs_pkg::*;
#(
  parameter int PATTERN_MAX  = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_regs_t               cfg,
  wbs_in_if.sink                  in_ch,
  input  logic                    q_full,
  output logic                    q_push,
  output scan_flags_t             q_flags,
  output logic [ADDRESS_BITS-1:0] q_base,
  output logic [ADDRESS_BITS-1:0] q_delta
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CW = (LW > LEN_REG_W) ? LW : LEN_REG_W;
  localparam int DW = (ADDRESS_BITS > DISP_W + 1) ? ADDRESS_BITS : DISP_W + 1;

  logic [7:0]       win_r   [PATTERN_MAX];
  logic [7:0]       win_nxt [PATTERN_MAX];
  logic [LW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    len_raw, len_c;
  logic [LW-1:0]    len;
  logic             off_err, resolve, hit;
  logic [PATTERN_MAX-1:0] miss_vec;
  logic [7:0]       disp_byte [4];
  logic [DISP_W-1:0] disp;
  logic signed [DISP_W:0] delta_s;
  logic signed [DW-1:0]   delta_w;

  assign q_push      = in_ch.valid && !q_full;
  assign in_ch.ready = !q_full;

  always_comb begin
    win_nxt[0] = in_ch.data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  assign fill_nxt = (fill_r == LW'(PATTERN_MAX)) ? fill_r : fill_r + 1'b1;

  always_comb begin
    len_raw = CW'(cfg.pattern_length);
    if (len_raw == '0) begin
      len_c = CW'(1);
    end else if (len_raw > CW'(PATTERN_MAX)) begin
      len_c = CW'(PATTERN_MAX);
    end else begin
      len_c = len_raw;
    end
  end
  assign len = len_c[LW-1:0];

  assign off_err = (cfg.relative_offset != '0) &&
                   ((CW+1)'(cfg.relative_offset) + (CW+1)'(4) > (CW+1)'(len));
  assign resolve = (cfg.relative_offset != '0) && !off_err;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cmp
    if (i < PAT_BYTES) begin : g_care
      logic [LW-1:0] pos;
      assign pos = len - 1'b1 - LW'(i);
      assign miss_vec[i] = (LW'(i) < len) && cfg.care_mask[i] &&
                           (win_nxt[pos[IW-1:0]] != cfg.pattern[8*i +: 8]);
    end else begin : g_wild
      assign miss_vec[i] = 1'b0;
    end
  end

  assign hit = (fill_nxt >= len) && !(|miss_vec);

  for (genvar j = 0; j < 4; j++) begin : g_disp
    logic [CW-1:0] pos;
    assign pos = CW'(len) - CW'(1) - CW'(cfg.relative_offset) - CW'(j);
    assign disp_byte[j] = win_nxt[pos[IW-1:0]];
  end

  assign disp    = {disp_byte[3], disp_byte[2], disp_byte[1], disp_byte[0]};
  assign delta_s = signed'({disp[DISP_W-1], disp}) + (DISP_W+1)'(cfg.relative_offset)
                 + (DISP_W+1)'(4);
  assign delta_w = DW'(delta_s);

  assign q_base  = in_ch.byte_address - ADDRESS_BITS'(len) + 1'b1;
  assign q_delta = resolve ? delta_w[ADDRESS_BITS-1:0] : '0;

  assign q_flags.hit       = hit;
  assign q_flags.last      = in_ch.last_in_range;
  assign q_flags.keep_last = cfg.keep_last;
  assign q_flags.off_err   = off_err;

  always_ff @(posedge clk) begin
    if (q_push) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (q_push) begin
      fill_r <= in_ch.last_in_range ? '0 : fill_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(PATTERN_MAX)) else $error("window fill out of range");
  a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && in_ch.last_in_range |=> fill_r == '0) else $error("fill not cleared");
  a_short_window: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && (fill_nxt < len) |-> !hit) else $error("match on short window");

endmodule

// ----- sv/wbs_back.sv -----
// ----------------------------------------------------------------------------
// wbs_back
// Resolves match addresses, keeps first or last match, issues range results.
// ----------------------------------------------------------------------------
module wbs_back
  import wbs_pkg::*;
#(
  parameter int ADDRESS_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  scan_flags_t             q_flags,
  input  logic [ADDRESS_BITS-1:0] q_base,
  input  logic [ADDRESS_BITS-1:0] q_delta,
  output logic                    q_pop,
  wbs_out_if.source               out_ch
);

  logic                    seen_r, seen_nxt;
  logic                    mult_r, mult_nxt;
  logic [ADDRESS_BITS-1:0] kept_r, kept_nxt;
  logic [ADDRESS_BITS-1:0] val;
  logic                    slot_free;
  logic                    out_valid_r;
  logic                    out_found_r;
  logic [ADDRESS_BITS-1:0] out_addr_r;
  logic                    out_mult_r;
  logic                    out_err_r;

  assign val       = q_base + q_delta;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = q_valid && (!q_flags.last || slot_free);

  always_comb begin
    seen_nxt = seen_r;
    mult_nxt = mult_r;
    kept_nxt = kept_r;
    if (q_flags.hit) begin
      if (q_flags.keep_last) begin
        mult_nxt = mult_r || seen_r;
        kept_nxt = val;
        seen_nxt = 1'b1;
      end else if (!seen_r) begin
        kept_nxt = val;
        seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kept_r <= kept_nxt;
    end
    if (q_pop && q_flags.last) begin
      out_found_r <= seen_nxt;
      out_addr_r  <= seen_nxt ? kept_nxt : '0;
      out_mult_r  <= q_flags.keep_last && mult_nxt;
      out_err_r   <= q_flags.off_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      mult_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_flags.last) begin
          seen_r      <= 1'b0;
          mult_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end else begin
          seen_r <= seen_nxt;
          mult_r <= mult_nxt;
        end
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.found            = out_found_r;
  assign out_ch.result_address   = out_addr_r;
  assign out_ch.multiple_matches = out_mult_r;
  assign out_ch.offset_error     = out_err_r;

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_addr_r == '0) else $error("address without match");
  a_mult_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_mult_r |-> out_found_r) else $error("multiple without match");
  a_range_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_flags.last |=> !seen_r && !mult_r && out_valid_r)
    else $error("range state not cleared");

endmodule

// ----- sv/wildcard_byte_pattern_scanner_core.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_core
// Scans an addressed byte stream for a masked pattern of up to 16 bytes.
//
//   port    dir  handshake      payload
//   in_ch   in   valid/ready    data_byte, byte_address, last_in_range
//   out_ch  out  valid/ready    found, result_address, multiple_matches,
//                               offset_error
//   cfg_*   in   cfg_we         cfg_index, cfg_data (write only)
//
// One byte per cycle while the queue is not full; the window compare
// and classify run in the cycle of acceptance, the two-entry queue and
// the back's resolve add follow, then the registered result slot.
// Synchronous active-low reset clears scan state and queue and sets the configuration to its defaults.
// The input stalls only when the queue is full, i.e. the result slot is held.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_core
  import wbs_pkg::*;
#(
  parameter int PATTERN_MAX  = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  wbs_in_if.sink               in_ch,
  wbs_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int REC_W = FLAGS_W + 2 * ADDRESS_BITS;

  cfg_regs_t               cfg_r;
  logic                    q_full, q_push, q_pop, q_valid;
  scan_flags_t             push_flags, pop_flags;
  logic [ADDRESS_BITS-1:0] push_base, push_delta, pop_base, pop_delta;
  logic [REC_W-1:0]        pop_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern         <= '0;
      cfg_r.care_mask       <= '1;
      cfg_r.pattern_length  <= LEN_REG_W'(1);
      cfg_r.relative_offset <= '0;
      cfg_r.keep_last       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PATTERN_LOW:     cfg_r.pattern[CFG_W-1:0]       <= cfg_data;
        CFG_PATTERN_HIGH:    cfg_r.pattern[2*CFG_W-1:CFG_W] <= cfg_data;
        CFG_CARE_MASK:       cfg_r.care_mask       <= cfg_data[PAT_BYTES-1:0];
        CFG_PATTERN_LENGTH:  cfg_r.pattern_length  <= cfg_data[LEN_REG_W-1:0];
        CFG_RELATIVE_OFFSET: cfg_r.relative_offset <= cfg_data[ROFF_W-1:0];
        CFG_KEEP_LAST:       cfg_r.keep_last       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wbs_front #(
    .PATTERN_MAX  (PATTERN_MAX),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_flags (push_flags),
    .q_base  (push_base),
    .q_delta (push_delta)
  );

  wbs_fifo #(
    .DATA_W (REC_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_flags, push_base, push_delta}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_rec),
    .not_empty (q_valid)
  );

  assign {pop_flags, pop_base, pop_delta} = pop_rec;

  wbs_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_flags (pop_flags),
    .q_base  (pop_base),
    .q_delta (pop_delta),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
